// ===== src/bmcr_pkg.sv =====
// Shared constants, command and status types, and search helpers for the column reducer.
`timescale 1ns / 1ps

package bmcr_pkg;

	// Fixed field widths.
	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int WORD_W = 64;
	localparam int BYTE_W = 8;
	localparam int NGRP   = WORD_W / BYTE_W;
	localparam int GRP_W  = $clog2(NGRP);
	localparam int LO_W   = $clog2(BYTE_W);

	// Default column capacity.
	localparam int MAX_COLUMNS_DEF = 64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_entry;
		logic load_grp;
		logic mem_rd;
		logic store;
		logic fold;
		logic birth;
		logic emit;
	} bmcr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic w_zero;
		logic taken;
		logic full;
		logic out_free;
	} bmcr_stat_t;

	// One flag per byte of the working column, set when the byte is nonzero.
	function automatic logic [NGRP-1:0] grp_any(input logic [WORD_W-1:0] w);
		logic [NGRP-1:0] any;
		for (int g = 0; g < NGRP; g++) begin
			any[g] = |w[g*BYTE_W +: BYTE_W];
		end
		return any;
	endfunction

	// Index of the highest set bit of a byte; zero when the byte is empty.
	function automatic logic [LO_W-1:0] top8(input logic [BYTE_W-1:0] v);
		logic [LO_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (v[i]) begin
				idx = LO_W'(i);
			end
		end
		return idx;
	endfunction

	// Index of the highest nonzero byte flag; zero when none is set.
	function automatic logic [GRP_W-1:0] top_grp(input logic [NGRP-1:0] v);
		logic [GRP_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NGRP; i++) begin
			if (v[i]) begin
				idx = GRP_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== src/bmcr_in_if.sv =====
// Input channel: one nonzero entry of a boundary-matrix column, or an empty-column marker, per transfer.
`timescale 1ns / 1ps

interface bmcr_in_if;
	logic                     valid;
	logic                     ready;
	logic [bmcr_pkg::ROW_W-1:0] row;
	logic                     last_in_column;
	logic                     empty_column;

	modport source(output valid, output row, output last_in_column, output empty_column,
		input ready);
	modport sink(input valid, input row, input last_in_column, input empty_column,
		output ready);
endinterface

// ===== src/bmcr_out_if.sv =====
// Output channel: one reduction result per transfer.
`timescale 1ns / 1ps

interface bmcr_out_if;
	logic                     valid;
	logic                     ready;
	logic [bmcr_pkg::COL_W-1:0] column;
	logic                     killed;
	logic [bmcr_pkg::ROW_W-1:0] partner;

	modport source(output valid, output column, output killed, output partner,
		input ready);
	modport sink(input valid, input column, input killed, input partner,
		output ready);
endinterface

// ===== src/boundary_matrix_column_reduction.sv =====
// Top level of the GF(2) boundary-matrix column reducer.
// Entries of a column arrive as row indices, one transfer per cycle while the block gathers;
// an entry with last_in_column, or an item with empty_column, closes the column. The column
// is then reduced: each round finds the highest set row, first the byte (ST_FIND_HI) and then
// the bit (ST_FIND_LO), and, when a reduced column is already stored under that row, reads it
// from the pivot memory and XORs it in (ST_XOR). A round is repeated for each stored column
// folded in, at most MAX_COLUMNS - 1 of them, and the column then waits in ST_EMIT for the
// result register to be free; input is not taken from the closing transfer until the result
// is loaded. The result names the column, and either the pivot row whose class it kills
// or a birth with partner 0. After MAX_COLUMNS columns the block keeps taking input and
// discards it.
`timescale 1ns / 1ps

module boundary_matrix_column_reduction #(
	parameter int MAX_COLUMNS = bmcr_pkg::MAX_COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bmcr_in_if.sink    in_ch,
	bmcr_out_if.source out_ch
);

	bmcr_pkg::bmcr_cmd_t  cmd;
	bmcr_pkg::bmcr_stat_t stat;

	// Sequencing.
	bmcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last_in_column),
		.in_empty (in_ch.empty_column),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	bmcr_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.row         (in_ch.row),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_column  (out_ch.column),
		.out_killed  (out_ch.killed),
		.out_partner (out_ch.partner)
	);

endmodule

// ===== src/bmcr_datapath.sv =====
// Datapath: working column, pivot search, reduced-column memory, counters and result register.
`timescale 1ns / 1ps

module bmcr_datapath #(
	parameter int MAX_COLUMNS = bmcr_pkg::MAX_COLUMNS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bmcr_pkg::bmcr_cmd_t          cmd,
	output bmcr_pkg::bmcr_stat_t         stat,
	input  logic [bmcr_pkg::ROW_W-1:0]   row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bmcr_pkg::COL_W-1:0]   out_column,
	output logic                         out_killed,
	output logic [bmcr_pkg::ROW_W-1:0]   out_partner
);

	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int DEPTH = 1 << bmcr_pkg::ROW_W;

	logic [bmcr_pkg::WORD_W-1:0] w_q;
	logic [bmcr_pkg::WORD_W-1:0] rd_q;
	logic [bmcr_pkg::WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            taken_q;
	logic [bmcr_pkg::GRP_W-1:0]  grp_q;
	logic [bmcr_pkg::ROW_W-1:0]  piv_q;
	logic                        killed_q;
	logic [CNT_W-1:0]            count_q;
	logic                        out_valid_q;
	logic [bmcr_pkg::COL_W-1:0]  out_column_q;
	logic                        out_killed_q;
	logic [bmcr_pkg::ROW_W-1:0]  out_partner_q;
	logic [bmcr_pkg::NGRP-1:0]   any;
	logic [bmcr_pkg::BYTE_W-1:0] byte_sel;
	logic [bmcr_pkg::ROW_W-1:0]  cur_piv;

	// Pivot search: highest byte first, then the highest bit inside it.
	assign any      = bmcr_pkg::grp_any(w_q);
	assign byte_sel = w_q[{grp_q, bmcr_pkg::LO_W'(0)} +: bmcr_pkg::BYTE_W];
	assign cur_piv  = {grp_q, bmcr_pkg::top8(byte_sel)};

	// Status toward the controller.
	assign stat.w_zero   = ~|any;
	assign stat.taken    = taken_q[cur_piv];
	assign stat.full     = (count_q == CNT_W'(MAX_COLUMNS));
	assign stat.out_free = ~out_valid_q | out_ready;

	// Working column: entries are ORed in, a stored column is XORed in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (cmd.emit) begin
			w_q <= '0;
		end else if (cmd.fold) begin
			w_q <= w_q ^ rd_q;
		end else if (cmd.take_entry) begin
			w_q <= w_q | (bmcr_pkg::WORD_W'(1) << row);
		end
	end

	// Search and pairing registers.
	always_ff @(posedge clk) begin
		if (cmd.load_grp) begin
			grp_q <= bmcr_pkg::top_grp(any);
		end
		if (cmd.store || cmd.mem_rd) begin
			piv_q <= cur_piv;
		end
		if (cmd.store) begin
			killed_q <= 1'b1;
		end else if (cmd.birth) begin
			killed_q <= 1'b0;
		end
	end

	// Reduced columns, addressed by pivot row.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[cur_piv] <= w_q;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[cur_piv];
		end
	end

	// Valid bits of the pivot table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (cmd.store) begin
			taken_q[cur_piv] <= 1'b1;
		end
	end

	// Column counter, saturating at capacity through the controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.emit) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Result register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_column_q  <= bmcr_pkg::COL_W'(count_q);
			out_killed_q  <= killed_q;
			out_partner_q <= killed_q ? piv_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_column  = out_column_q;
	assign out_killed  = out_killed_q;
	assign out_partner = out_partner_q;

endmodule

// ===== src/bmcr_ctrl.sv =====
// Controller: state machine that gathers entries and sequences the reduction of each column.
`timescale 1ns / 1ps

module bmcr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	input  logic                 in_empty,
	output logic                 in_ready,
	input  bmcr_pkg::bmcr_stat_t stat,
	output bmcr_pkg::bmcr_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_GATHER  = 5'b00001,
		ST_FIND_HI = 5'b00010,
		ST_FIND_LO = 5'b00100,
		ST_XOR     = 5'b01000,
		ST_EMIT    = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_GATHER);
	assign accept   = in_valid & in_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_GATHER: begin
				if (accept && !stat.full) begin
					cmd.take_entry = ~in_empty;
					if (in_empty || in_last) begin
						state_d = ST_FIND_HI;
					end
				end
			end
			ST_FIND_HI: begin
				if (stat.w_zero) begin
					cmd.birth = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					cmd.load_grp = 1'b1;
					state_d      = ST_FIND_LO;
				end
			end
			ST_FIND_LO: begin
				if (stat.taken) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_XOR;
				end else begin
					cmd.store = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_XOR: begin
				cmd.fold = 1'b1;
				state_d  = ST_FIND_HI;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_GATHER;
				end
			end
			default: begin
				state_d = ST_GATHER;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_GATHER;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/bmcr_checker.sv =====
// Port-level checks for the column reducer, bound to the top level.
`timescale 1ns / 1ps

module bmcr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_killed,
	input logic [bmcr_pkg::COL_W-1:0] out_column,
	input logic [bmcr_pkg::ROW_W-1:0] out_partner
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_killed)
			&& $stable(out_partner))
		else $error("result changed while stalled");

	// A birth carries partner zero.
	a_birth_partner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_killed |-> out_partner == '0)
		else $error("birth with nonzero partner");

	// A new result comes only out of a reduction, when input was held off.
	a_new_after_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while gathering");

	// Gathering resumes in the cycle a fresh result is loaded.
	a_no_take_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("gathering not resumed after result load");

endmodule

bind boundary_matrix_column_reduction bmcr_checker u_bmcr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_killed  (out_ch.killed),
	.out_column  (out_ch.column),
	.out_partner (out_ch.partner)
);
